FILE: sv/srl_pkg.sv
// Shared types, constants and helpers for the SYN flow rate limiter.
// No dependencies; every other file but srl_ram imports this package.
package srl_pkg;

  localparam int TABLE_SETS_DEF = 256;
  localparam int TABLE_WAYS_DEF = 4;
  localparam int QUEUE_DEPTH    = 4;
  localparam int SET_W_MAX      = 12;

  localparam logic [31:0] HASH_MUL    = 32'h61C8_8647;
  localparam logic [10:0] REMOVED_MAX = 11'd2047;

  localparam logic [7:0]  MAX_CONN_RESET = 8'd5;
  localparam logic [30:0] WINDOW_RESET   = 31'd5000;

  localparam logic REG_MAX_CONN = 1'b0;
  localparam logic REG_WINDOW   = 1'b1;

  typedef struct packed {
    logic        operation;
    logic        is_tcp;
    logic        is_syn;
    logic [31:0] src_addr;
    logic [31:0] dest_ip;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    logic        drop;
    logic        tracked;
    logic [10:0] removed_count;
  } out_item_t;

  typedef enum logic [1:0] {
    REQ_BYPASS = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_SWEEP  = 2'd2
  } req_kind_t;

  typedef struct packed {
    req_kind_t              kind;
    logic [31:0]            src;
    logic [31:0]            dst;
    logic [31:0]            now;
    logic [SET_W_MAX-1:0]   set;
  } req_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] source;
    logic [31:0] dest;
    logic [31:0] start;
    logic [7:0]  count;
  } entry_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  // A window has run out once start + window - now is negative as a
  // signed 32-bit value.
  function automatic logic win_expired(logic [31:0] start, logic [30:0] window,
                                       logic [31:0] now);
    logic [31:0] d;
    d = start + {1'b0, window} - now;
    return d[31];
  endfunction

endpackage

FILE: sv/syn_flow_rate_limiter_top.sv
// Structure: two hash multiply stages and a queue ahead of the table engine.
// Throughput: a looked-up packet needs a set read, then compare and write back
// through the way RAMs before the next is taken; one bypassed packet per cycle
// while the output is not stalled, a sweep one set a cycle.
// Reset: synchronous; afterwards a clearing pass writes every set's valid bits
// to zero, in_ready stays low until it ends. Registers reset too.
module syn_flow_rate_limiter_top import srl_pkg::*; #(
  parameter int TABLE_SETS = TABLE_SETS_DEF,
  parameter int TABLE_WAYS = TABLE_WAYS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [30:0] cfg_data
);

  logic [7:0]   conn_limit;
  logic [30:0]  window_ticks;
  logic         q_in_valid, q_in_ready, q_out_valid, q_out_ready;
  req_t         q_in_req, q_out_req;
  back_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      conn_limit   <= MAX_CONN_RESET;
      window_ticks <= WINDOW_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAX_CONN: conn_limit   <= cfg_data[7:0];
        REG_WINDOW:   window_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  srl_front #(.TABLE_SETS(TABLE_SETS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .status  (status),
    .q_valid (q_in_valid),
    .q_ready (q_in_ready),
    .q_req   (q_in_req)
  );

  srl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_in_valid),
    .in_ready (q_in_ready),
    .in_req   (q_in_req),
    .out_valid(q_out_valid),
    .out_ready(q_out_ready),
    .out_req  (q_out_req)
  );

  srl_back #(.TABLE_SETS(TABLE_SETS), .TABLE_WAYS(TABLE_WAYS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .conn_limit  (conn_limit),
    .window_ticks(window_ticks),
    .q_valid     (q_out_valid),
    .q_ready     (q_out_ready),
    .q_req       (q_out_req),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .status      (status)
  );

endmodule

FILE: sv/srl_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
module srl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/srl_front.sv
// Front end: accepts items, classifies them and hashes the source address
// to a set index over two multiply stages. Uses srl_pkg.
module srl_front import srl_pkg::*; #(
  parameter int TABLE_SETS = TABLE_SETS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  in_item_t     in_data,
  input  back_status_t status,
  output logic         q_valid,
  input  logic         q_ready,
  output req_t         q_req
);

  localparam int SW = (TABLE_SETS > 1) ? $clog2(TABLE_SETS) : 1;

  logic        s1_valid;
  in_item_t    s1_item;
  req_kind_t   s1_kind;
  logic [31:0] s1_h;
  logic        s2_valid;
  req_t        s2_req;

  logic        s1_take, s2_take;
  req_kind_t   kind_in;
  logic [31:0] h_in;
  logic [63:0] prod2;

  assign s2_take  = !s2_valid || q_ready;
  assign s1_take  = !s1_valid || s2_take;
  assign in_ready = s1_take && !status.clearing;

  always_comb begin
    if (in_data.operation) begin
      kind_in = REQ_SWEEP;
    end else if (in_data.is_tcp && in_data.is_syn && in_data.src_addr != in_data.dest_ip) begin
      kind_in = REQ_LOOKUP;
    end else begin
      kind_in = REQ_BYPASS;
    end
  end

  assign h_in  = in_data.src_addr * HASH_MUL;
  assign prod2 = {32'd0, s1_h} * 64'(TABLE_SETS);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (s2_take) begin
        s1_valid <= 1'b0;
      end
      if (s2_take) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
      s1_kind <= kind_in;
      s1_h    <= h_in;
    end
    if (s2_take) begin
      s2_req.kind <= s1_kind;
      s2_req.src  <= s1_item.src_addr;
      s2_req.dst  <= s1_item.dest_ip;
      s2_req.now  <= s1_item.now;
      s2_req.set  <= SET_W_MAX'(prod2[32 +: SW]);
    end
  end

  assign q_valid = s2_valid;
  assign q_req   = s2_req;

endmodule

FILE: sv/srl_queue.sv
// Short request queue between front end and table engine.
// Uses srl_pkg for the request type.
module srl_queue import srl_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic out_valid,
  input  logic out_ready,
  output req_t out_req
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  req_t          slots [DEPTH];
  logic [PW-1:0] head, tail;
  logic [CW-1:0] count;
  logic          push, pop;

  assign in_ready  = count != CW'(DEPTH);
  assign out_valid = count != '0;
  assign out_req   = slots[head];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == PW'(DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (pop) begin
        head <= (head == PW'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= in_req;
    end
  end

endmodule

FILE: sv/srl_back.sv
// Table engine: set-associative flow table in one RAM per way, packet
// lookup and update, expiry sweep and the clearing pass after reset.
// Uses srl_pkg and srl_ram.
module srl_back import srl_pkg::*; #(
  parameter int TABLE_SETS = TABLE_SETS_DEF,
  parameter int TABLE_WAYS = TABLE_WAYS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [7:0]   conn_limit,
  input  logic [30:0]  window_ticks,
  input  logic         q_valid,
  output logic         q_ready,
  input  req_t         q_req,
  output logic         out_valid,
  input  logic         out_ready,
  output out_item_t    out_data,
  output back_status_t status
);

  localparam int SW = (TABLE_SETS > 1) ? $clog2(TABLE_SETS) : 1;
  localparam int CW = $clog2(TABLE_SETS + 1);
  localparam int WW = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
  localparam int NW = $clog2(TABLE_WAYS + 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EVAL  = 5'b00100,
    S_SWEEP = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] clear_idx, clear_idx_next;
  logic [CW-1:0] issue_idx, issue_idx_next;
  logic          pend, pend_next;
  logic [SW-1:0] pend_set, pend_set_next;
  logic [10:0]   removed, removed_next;
  req_t          cur_req, cur_req_next;
  out_item_t     out_data_next;
  logic          out_load;

  logic                  rd_en;
  logic [SW-1:0]         rd_addr;
  logic [SW-1:0]         waddr;
  logic [TABLE_WAYS-1:0] we;
  entry_t                wdata [TABLE_WAYS];
  entry_t                rdata [TABLE_WAYS];

  logic [TABLE_WAYS-1:0] hit_vec, free_vec, exp_vec, gone_vec;
  logic                  hit_any, free_any;
  logic [WW-1:0]         hit_idx, free_idx;
  entry_t                hit_e;
  logic                  hit_exp;
  logic                  out_free;
  logic [NW-1:0]         gone_n;
  logic [11:0]           removed_sum;

  for (genvar w = 0; w < TABLE_WAYS; w++) begin : g_way
    srl_ram #(
      .WIDTH($bits(entry_t)),
      .DEPTH(TABLE_SETS)
    ) u_ram (
      .clk  (clk),
      .we   (we[w]),
      .waddr(waddr),
      .wdata(wdata[w]),
      .re   (rd_en),
      .raddr(rd_addr),
      .rdata(rdata[w])
    );
    assign hit_vec[w]  = rdata[w].valid && rdata[w].source == cur_req.src &&
                         rdata[w].dest == cur_req.dst;
    assign free_vec[w] = !rdata[w].valid;
    assign exp_vec[w]  = win_expired(rdata[w].start, window_ticks, cur_req.now);
    assign gone_vec[w] = rdata[w].valid && exp_vec[w];
  end

  // Lowest matching way and lowest free way.
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int w = 0; w < TABLE_WAYS; w++) begin
      if (hit_vec[w] && !hit_any) begin
        hit_any = 1'b1;
        hit_idx = WW'(w);
      end
      if (free_vec[w] && !free_any) begin
        free_any = 1'b1;
        free_idx = WW'(w);
      end
    end
  end

  assign hit_e       = rdata[hit_idx];
  assign hit_exp     = exp_vec[hit_idx];
  assign out_free    = !out_valid || out_ready;
  assign gone_n      = NW'($countones(gone_vec));
  assign removed_sum = {1'b0, removed} + 12'(gone_n);

  always_comb begin
    state_next     = state;
    clear_idx_next = clear_idx;
    issue_idx_next = issue_idx;
    pend_next      = pend;
    pend_set_next  = pend_set;
    removed_next   = removed;
    cur_req_next   = cur_req;
    out_load       = 1'b0;
    out_data_next  = '0;
    q_ready        = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = q_req.set[SW-1:0];
    waddr          = cur_req.set[SW-1:0];
    we             = '0;
    for (int w = 0; w < TABLE_WAYS; w++) begin
      wdata[w] = rdata[w];
    end

    case (state)
      S_CLEAR: begin
        waddr = clear_idx[SW-1:0];
        we    = '1;
        for (int w = 0; w < TABLE_WAYS; w++) begin
          wdata[w].valid = 1'b0;
        end
        clear_idx_next = clear_idx + 1'b1;
        if (clear_idx == CW'(TABLE_SETS - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (q_valid) begin
          case (q_req.kind)
            REQ_LOOKUP: begin
              q_ready      = 1'b1;
              rd_en        = 1'b1;
              cur_req_next = q_req;
              state_next   = S_EVAL;
            end
            REQ_SWEEP: begin
              q_ready        = 1'b1;
              cur_req_next   = q_req;
              issue_idx_next = '0;
              pend_next      = 1'b0;
              removed_next   = '0;
              state_next     = S_SWEEP;
            end
            default: begin
              if (out_free) begin
                q_ready  = 1'b1;
                out_load = 1'b1;
              end
            end
          endcase
        end
      end

      S_EVAL: begin
        if (out_free) begin
          out_load = 1'b1;
          for (int w = 0; w < TABLE_WAYS; w++) begin
            wdata[w].valid  = 1'b1;
            wdata[w].source = cur_req.src;
            wdata[w].dest   = cur_req.dst;
            wdata[w].start  = cur_req.now;
            wdata[w].count  = 8'd1;
          end
          if (hit_any) begin
            out_data_next.tracked = 1'b1;
            if (hit_exp) begin
              we[hit_idx] = 1'b1;
            end else if (hit_e.count >= conn_limit) begin
              out_data_next.drop = 1'b1;
            end else begin
              we[hit_idx] = 1'b1;
              for (int w = 0; w < TABLE_WAYS; w++) begin
                wdata[w].start = hit_e.start;
                wdata[w].count = hit_e.count + 8'd1;
              end
            end
          end else if (free_any) begin
            out_data_next.tracked = 1'b1;
            we[free_idx]          = 1'b1;
          end
          state_next = S_IDLE;
        end
      end

      S_SWEEP: begin
        // Each row is written back in the cycle after its read.
        waddr = pend_set;
        if (pend) begin
          we = '1;
          for (int w = 0; w < TABLE_WAYS; w++) begin
            wdata[w].valid = rdata[w].valid && !exp_vec[w];
          end
          removed_next = (removed_sum > 12'(REMOVED_MAX)) ? REMOVED_MAX : removed_sum[10:0];
        end
        if (issue_idx != CW'(TABLE_SETS)) begin
          rd_en          = 1'b1;
          rd_addr        = issue_idx[SW-1:0];
          pend_next      = 1'b1;
          pend_set_next  = issue_idx[SW-1:0];
          issue_idx_next = issue_idx + 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            state_next = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_load                    = 1'b1;
          out_data_next.removed_count = removed;
          state_next                  = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clear_idx <= '0;
      issue_idx <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clear_idx <= clear_idx_next;
      issue_idx <= issue_idx_next;
      pend      <= pend_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_set <= pend_set_next;
    removed  <= removed_next;
    cur_req  <= cur_req_next;
    if (out_load) begin
      out_data <= out_data_next;
    end
  end

  assign status.clearing = state == S_CLEAR;

endmodule

FILE: sv/srl_checker.sv
// Port-level checks on the rate limiter top level, bound to it below.
// Uses srl_pkg for the result type.
module srl_checker import srl_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("stalled result changed");

  a_drop_tracked: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.drop |-> out_data.tracked && out_data.removed_count == '0)
    else $error("dropped request not tracked or carries a sweep count");

  a_sweep_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.removed_count != '0 |-> !out_data.drop && !out_data.tracked)
    else $error("sweep result with packet flags");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready)
    else $error("request taken during the clearing pass");

endmodule

bind syn_flow_rate_limiter_top srl_checker u_srl_checker (.*);

FILE: sim/syn_flow_rate_limiter_top_tb.sv
// Testbench for syn_flow_rate_limiter_top: directed and random SYN traffic and sweeps,
// checked against a behavioral flow table kept in the testbench. Depends on srl_pkg.
module syn_flow_rate_limiter_top_tb;
  import srl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETS = TABLE_SETS_DEF;
  localparam int WAYS = TABLE_WAYS_DEF;
  localparam int SLOTS = SETS * WAYS;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_write = 1'b0;
  logic cfg_index = REG_MAX_CONN;
  logic [30:0] cfg_data = '0;

  syn_flow_rate_limiter_top uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Flow table as the testbench sees it.
  logic        flow_valid [SLOTS];
  logic [31:0] flow_src [SLOTS];
  logic [31:0] flow_dst [SLOTS];
  logic [31:0] flow_start [SLOTS];
  logic [7:0]  flow_count [SLOTS];
  logic [7:0]  limit_cfg = MAX_CONN_RESET;
  logic [30:0] window_cfg = WINDOW_RESET;

  out_item_t verdicts [$];
  int errors = 0;
  int results_seen = 0;
  int drops_seen = 0;
  int sweeps_sent = 0;
  int send_idle = 0;
  int recv_stall = 0;
  logic [31:0] tick = 32'd100;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  function automatic int flow_set(logic [31:0] src);
    logic [31:0] h;
    logic [63:0] s;
    h = src * HASH_MUL;
    s = ({32'd0, h} * SETS) >> 32;
    return int'(s);
  endfunction

  function automatic logic ran_out(logic [31:0] start, logic [31:0] at);
    logic [31:0] d;
    d = start + {1'b0, window_cfg} - at;
    return d[31];
  endfunction

  function automatic out_item_t judge(in_item_t req);
    out_item_t r;
    int base, hit, free_slot;
    r = '0;
    if (req.operation) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (flow_valid[i] && ran_out(flow_start[i], req.now)) begin
          flow_valid[i] = 1'b0;
          if (r.removed_count < REMOVED_MAX) r.removed_count++;
        end
      end
    end else if (req.is_tcp && req.is_syn && req.src_addr != req.dest_ip) begin
      base = flow_set(req.src_addr) * WAYS;
      hit = -1;
      free_slot = -1;
      for (int w = 0; w < WAYS; w++) begin
        if (flow_valid[base + w]) begin
          if (hit < 0 && flow_src[base + w] == req.src_addr &&
              flow_dst[base + w] == req.dest_ip) hit = base + w;
        end else if (free_slot < 0) begin
          free_slot = base + w;
        end
      end
      if (hit >= 0) begin
        r.tracked = 1'b1;
        if (ran_out(flow_start[hit], req.now)) begin
          flow_start[hit] = req.now;
          flow_count[hit] = 8'd1;
        end else if (flow_count[hit] >= limit_cfg) begin
          r.drop = 1'b1;
        end else begin
          flow_count[hit] = flow_count[hit] + 8'd1;
        end
      end else if (free_slot >= 0) begin
        flow_valid[free_slot] = 1'b1;
        flow_src[free_slot] = req.src_addr;
        flow_dst[free_slot] = req.dest_ip;
        flow_start[free_slot] = req.now;
        flow_count[free_slot] = 8'd1;
        r.tracked = 1'b1;
      end
    end
    return r;
  endfunction

  // Valid stays high from one request to the next when there is no idle gap;
  // drain() lowers it once the traffic ends.
  task automatic send_request(in_item_t req);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    verdicts.push_back(judge(req));
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_ready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
  end

  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (verdicts.size() == 0) begin
        $error("result with nothing expected: %p", out_data);
        errors++;
      end else begin
        exp_r = verdicts.pop_front();
        if (out_data.drop) drops_seen++;
        if (out_data.drop !== exp_r.drop) begin
          $error("drop expected %0d got %0d", exp_r.drop, out_data.drop);
          errors++;
        end
        if (out_data.tracked !== exp_r.tracked) begin
          $error("tracked expected %0d got %0d", exp_r.tracked, out_data.tracked);
          errors++;
        end
        if (out_data.removed_count !== exp_r.removed_count) begin
          $error("removed_count expected %0d got %0d", exp_r.removed_count,
                 out_data.removed_count);
          errors++;
        end
      end
    end
  end

  task automatic drain();
    in_valid <= 1'b0;
    while (verdicts.size() != 0) @(negedge clk);
    repeat (SETS + 20) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [30:0] value);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_MAX_CONN) limit_cfg = value[7:0];
    else window_cfg = value;
  endtask

  function automatic in_item_t syn_req(logic [31:0] src, logic [31:0] dst,
                                       logic [31:0] at);
    in_item_t r;
    r = '0;
    r.is_tcp = 1'b1;
    r.is_syn = 1'b1;
    r.src_addr = src;
    r.dest_ip = dst;
    r.now = at;
    return r;
  endfunction

  task automatic sweep_at(logic [31:0] at);
    in_item_t r;
    r = '0;
    r.operation = 1'b1;
    r.is_tcp = 1'($urandom_range(1));
    r.src_addr = $urandom();
    r.now = at;
    sweeps_sent++;
    send_request(r);
  endtask

  task automatic test_directed();
    in_item_t r;
    // Bypass cases: not TCP, not SYN, equal addresses.
    r = syn_req(32'hFFFF_FFFF, 32'h0, 32'h0);
    r.is_tcp = 1'b0;
    send_request(r);
    r.is_tcp = 1'b1;
    r.is_syn = 1'b0;
    send_request(r);
    send_request(syn_req(32'h0A00_0001, 32'h0A00_0001, tick));
    // One flow up to and past the default limit, then window expiry.
    for (int k = 0; k < 7; k++) send_request(syn_req(32'h0A00_0001, 32'hC0A8_0001, tick));
    send_request(syn_req(32'h0A00_0001, 32'hC0A8_0001, tick + 32'd5001));
    // Fill one set past its ways: same source, many destinations (fail-open).
    for (int k = 0; k < WAYS + 2; k++)
      send_request(syn_req(32'h0, 32'h1000 + k, tick));
    // Extremes of the tick counter, including wraparound.
    send_request(syn_req(32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF));
    send_request(syn_req(32'hFFFF_FFFF, 32'h1, 32'h0000_0010));
    sweep_at(tick + 32'd5000);
    sweep_at(tick + 32'd20000);
    sweep_at(tick + 32'd20000);
  endtask

  task automatic random_burst(int n, int pool);
    logic [31:0] srcs [8];
    int pick;
    in_item_t r;
    for (int i = 0; i < 8; i++) srcs[i] = $urandom();
    for (int i = 0; i < n; i++) begin
      tick = tick + $urandom_range(window_cfg > 40 ? 40 : 3);
      pick = $urandom_range(99);
      if (pick < 4) begin
        sweep_at(tick);
      end else if (pick < 14) begin
        r = '0;
        r.operation = 1'b0;
        r.is_tcp = 1'($urandom_range(1));
        r.is_syn = 1'($urandom_range(1));
        r.src_addr = $urandom();
        r.dest_ip = $urandom_range(1) ? r.src_addr : $urandom();
        r.now = $urandom();
        send_request(r);
      end else begin
        send_request(syn_req(srcs[$urandom_range(pool - 1)],
                             32'hC000_0000 | $urandom_range(pool), tick));
      end
    end
  endtask

  task automatic test_random_phases();
    int idle_plan [4][2] = '{'{0, 0}, '{47, 0}, '{0, 47}, '{28, 28}};
    for (int p = 0; p < 4; p++) begin
      send_idle = idle_plan[p][0];
      recv_stall = idle_plan[p][1];
      random_burst(150, 3 + p);
    end
    send_idle = 0;
    recv_stall = 0;
  endtask

  task automatic test_config_extremes();
    write_reg(REG_MAX_CONN, 31'd1);
    write_reg(REG_WINDOW, 31'd30);
    random_burst(150, 4);
    write_reg(REG_MAX_CONN, 31'd255);
    write_reg(REG_WINDOW, 31'h7FFF_FFFF);
    random_burst(150, 2);
    sweep_at(tick + 32'h8000_0000);
    write_reg(REG_MAX_CONN, 31'd0);
    write_reg(REG_WINDOW, 31'd0);
    random_burst(100, 3);
    write_reg(REG_MAX_CONN, 31'd3);
    write_reg(REG_WINDOW, 31'd200);
    send_idle = 28;
    recv_stall = 28;
    random_burst(200, 5);
    send_idle = 0;
    recv_stall = 0;
    random_burst(100, 8);
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      flow_valid[i] = 1'b0;
      flow_src[i] = '0;
      flow_dst[i] = '0;
      flow_start[i] = '0;
      flow_count[i] = '0;
    end
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_phases();
    test_config_extremes();
    drain();
    $display("Covered %0d results, %0d drops and %0d sweeps over several limits and windows.",
             results_seen, drops_seen, sweeps_sent);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
